// File: rtl/assert_macros.svh
// Assertion macros for the checker file cfc_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle or overlapping implication, checked outside reset.
`define CFC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Antecedent this cycle, consequent at the next edge.
`define CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/cfc_pkg.sv
// Shared types and constants for the camera frame capture framer.
// No dependencies.
package cfc_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned DIM_W     = 10;
	localparam int unsigned COL_W     = DIM_W + 1;
	localparam int unsigned HDR_LEN   = 10;
	localparam int unsigned TRL_LEN   = 2;
	localparam int unsigned IDX_W     = $clog2(HDR_LEN);
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = DIM_W;

	localparam logic [DIM_W-1:0]  WIDTH_RST   = DIM_W'(320);
	localparam logic [DIM_W-1:0]  HEIGHT_RST  = DIM_W'(240);
	localparam logic [BYTE_W-1:0] TRAILER_BYTE = 8'hFF;

	// register index codes
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_VS_HIGH,
		PH_VS_LOW,
		PH_HREF_HIGH,
		PH_PCLK_HIGH,
		PH_PCLK_LOW,
		PH_HREF_LOW,
		PH_VS_END
	} phase_t;

	typedef enum logic [1:0] {
		BURST_BYTE,
		BURST_HEADER,
		BURST_TRAILER
	} burst_kind_t;

	// one item's results, handed from the controller to the emitter
	typedef struct packed {
		logic              valid;
		burst_kind_t       kind;
		logic [BYTE_W-1:0] data;
	} burst_t;

	function automatic logic [BYTE_W-1:0] header_byte(input logic [IDX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		case (idx)
			4'd0:    b = 8'h53;
			4'd1:    b = 8'h5A;
			4'd2:    b = 8'h48;
			4'd3:    b = 8'h59;
			4'd4:    b = 8'h00;
			4'd5:    b = 8'h0C;
			4'd6:    b = 8'h58;
			4'd7:    b = 8'h02;
			4'd8:    b = 8'h00;
			4'd9:    b = 8'h02;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// File: rtl/cfc_if.sv
// Valid/ready channel interfaces: pin samples in, packet words out.
// Depends on cfc_pkg.
interface cfc_pix_if;
	logic                       valid;
	logic                       ready;
	logic                       start_req;
	logic                       vsync;
	logic                       href;
	logic                       pclk;
	logic [cfc_pkg::BYTE_W-1:0] pixel_byte;

	modport source (output valid, start_req, vsync, href, pclk, pixel_byte, input ready);
	modport sink (input valid, start_req, vsync, href, pclk, pixel_byte, output ready);
endinterface

interface cfc_pkt_if;
	logic                       valid;
	logic                       ready;
	logic [cfc_pkg::BYTE_W-1:0] tx_byte;
	logic                       run_last;
	logic                       packet_end;

	modport source (output valid, tx_byte, run_last, packet_end, input ready);
	modport sink (input valid, tx_byte, run_last, packet_end, output ready);
endinterface

// File: rtl/camera_frame_capture_framer_unit.sv
// Top level of the camera frame capture framer: sequencer plus output stage.
// Depends on cfc_pkg, cfc_if, cfc_ctrl and cfc_emit.
//
// Takes one sample of the camera pins per pix word and builds the packet:
// a 10-word header on start, two words per pixel on pclk rising samples,
// and the FF FF trailer on vsync after the last row. A sample is taken every
// cycle while the output stage is empty or sending the last word of the
// previous sample's run, so samples that yield zero or one word stream at one
// per cycle; a header or trailer sample holds pix.ready low until its last word
// is sent, as the output stage sends one word a cycle while pkt.ready is high.
// frame_width and frame_height are written through cfg_we/cfg_idx/cfg_data.
module camera_frame_capture_framer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data,
	cfc_pix_if.sink                        pix,
	cfc_pkt_if.source                      pkt
);

	cfc_pkg::burst_t burst;
	logic            emit_free;

	cfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.pix       (pix),
		.emit_free (emit_free),
		.burst     (burst)
	);

	cfc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.burst     (burst),
		.emit_free (emit_free),
		.pkt       (pkt)
	);

endmodule

// File: rtl/cfc_ctrl.sv
// Capture sequencer: config registers, phase FSM, row-byte and row counters.
// Depends on cfc_pkg and cfc_pix_if.
module cfc_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data,
	cfc_pix_if.sink                       pix,
	input  logic                          emit_free,
	output cfc_pkg::burst_t               burst
);

	cfc_pkg::phase_t                phase_q, phase_d;
	logic [cfc_pkg::DIM_W-1:0]      width_q, height_q;
	logic [cfc_pkg::COL_W-1:0]      col_q, col_d;
	logic [cfc_pkg::DIM_W-1:0]      row_q, row_d;
	logic                           fire;
	cfc_pkg::burst_t                burst_d;

	assign pix.ready = emit_free;
	assign fire      = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cfc_pkg::WIDTH_RST;
			height_q <= cfc_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				cfc_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data;
				cfc_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfc_pkg::PH_IDLE;
			col_q   <= '0;
			row_q   <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
		end
	end

	always_comb begin
		phase_d       = phase_q;
		col_d         = col_q;
		row_d         = row_q;
		burst_d.valid = 1'b0;
		burst_d.kind  = cfc_pkg::BURST_BYTE;
		burst_d.data  = pix.pixel_byte;
		case (phase_q)
			cfc_pkg::PH_IDLE: begin
				if (pix.start_req) begin
					burst_d.valid = 1'b1;
					burst_d.kind  = cfc_pkg::BURST_HEADER;
					phase_d       = cfc_pkg::PH_VS_HIGH;
				end
			end
			cfc_pkg::PH_VS_HIGH: begin
				if (pix.vsync)
					phase_d = cfc_pkg::PH_VS_LOW;
			end
			cfc_pkg::PH_VS_LOW: begin
				if (!pix.vsync) begin
					row_d   = '0;
					phase_d = (height_q == '0) ? cfc_pkg::PH_VS_END : cfc_pkg::PH_HREF_HIGH;
				end
			end
			cfc_pkg::PH_HREF_HIGH: begin
				if (pix.href) begin
					col_d   = '0;
					phase_d = (width_q == '0) ? cfc_pkg::PH_HREF_LOW : cfc_pkg::PH_PCLK_HIGH;
				end
			end
			cfc_pkg::PH_PCLK_HIGH: begin
				if (pix.pclk) begin
					burst_d.valid = 1'b1;
					col_d         = col_q + cfc_pkg::COL_W'(1);
					phase_d       = cfc_pkg::PH_PCLK_LOW;
				end
			end
			cfc_pkg::PH_PCLK_LOW: begin
				// two bytes per pixel
				if (!pix.pclk)
					phase_d = (col_q >= {width_q, 1'b0}) ? cfc_pkg::PH_HREF_LOW
					                                     : cfc_pkg::PH_PCLK_HIGH;
			end
			cfc_pkg::PH_HREF_LOW: begin
				if (!pix.href) begin
					row_d   = row_q + cfc_pkg::DIM_W'(1);
					phase_d = (row_d >= height_q) ? cfc_pkg::PH_VS_END : cfc_pkg::PH_HREF_HIGH;
				end
			end
			cfc_pkg::PH_VS_END: begin
				if (pix.vsync) begin
					burst_d.valid = 1'b1;
					burst_d.kind  = cfc_pkg::BURST_TRAILER;
					phase_d       = cfc_pkg::PH_IDLE;
				end
			end
			default: phase_d = cfc_pkg::PH_IDLE;
		endcase
	end

	always_comb begin
		burst       = burst_d;
		burst.valid = burst_d.valid && fire;
	end

endmodule

// File: rtl/cfc_emit.sv
// Output stage: holds one item's results and sends them one word a cycle while pkt.ready is high.
// Depends on cfc_pkg and cfc_pkt_if.
module cfc_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  cfc_pkg::burst_t burst,
	output logic            emit_free,
	cfc_pkt_if.source       pkt
);

	logic                        busy_q;
	cfc_pkg::burst_kind_t        kind_q;
	logic [cfc_pkg::BYTE_W-1:0]  data_q;
	logic [cfc_pkg::IDX_W-1:0]   idx_q;
	logic                        last;

	always_comb begin
		case (kind_q)
			cfc_pkg::BURST_HEADER: begin
				pkt.tx_byte = cfc_pkg::header_byte(idx_q);
				last        = (idx_q == cfc_pkg::IDX_W'(cfc_pkg::HDR_LEN - 1));
			end
			cfc_pkg::BURST_TRAILER: begin
				pkt.tx_byte = cfc_pkg::TRAILER_BYTE;
				last        = (idx_q == cfc_pkg::IDX_W'(cfc_pkg::TRL_LEN - 1));
			end
			default: begin
				pkt.tx_byte = data_q;
				last        = 1'b1;
			end
		endcase
	end

	assign pkt.valid      = busy_q;
	assign pkt.run_last   = last;
	assign pkt.packet_end = last && (kind_q == cfc_pkg::BURST_TRAILER);
	// free now, or the final word of the run goes out this cycle
	assign emit_free      = !busy_q || (last && pkt.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			kind_q <= cfc_pkg::BURST_BYTE;
		end else if (burst.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			kind_q <= burst.kind;
		end else if (busy_q && pkt.ready) begin
			if (last)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + cfc_pkg::IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (burst.valid)
			data_q <= burst.data;
	end

endmodule

// File: rtl/cfc_checker.sv
// Port-level checks for the framer, bound onto the top level.
// Depends on cfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cfc_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pix_ready,
	input logic                       pkt_valid,
	input logic                       pkt_ready,
	input logic [cfc_pkg::BYTE_W-1:0] pkt_tx_byte,
	input logic                       pkt_run_last,
	input logic                       pkt_packet_end
);

	logic stalled;
	logic end_ok;

	assign stalled = pkt_valid && !pkt_ready;
	assign end_ok  = pkt_run_last && (pkt_tx_byte == cfc_pkg::TRAILER_BYTE);

	// a stalled word holds
	`CFC_ASSERT_NEXT(a_pkt_hold, clk, arst_n, stalled, pkt_valid && $stable({pkt_tx_byte, pkt_run_last}))

	// packet end is the last word of its run and a trailer byte
	`CFC_ASSERT(a_end_is_last, clk, arst_n, pkt_valid && pkt_packet_end |-> end_ok)

	// no new sample mid-run
	`CFC_ASSERT(a_no_take_mid_run, clk, arst_n, pkt_valid && !pkt_run_last |-> !pix_ready)

	// ready for a sample whenever the output stage is idle
	`CFC_ASSERT(a_ready_when_idle, clk, arst_n, !pkt_valid |-> pix_ready)

endmodule

bind camera_frame_capture_framer_unit cfc_checker u_cfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pix_ready      (pix.ready),
	.pkt_valid      (pkt.valid),
	.pkt_ready      (pkt.ready),
	.pkt_tx_byte    (pkt.tx_byte),
	.pkt_run_last   (pkt.run_last),
	.pkt_packet_end (pkt.packet_end)
);

// File: dv/cfc_packet_checker.sv
`timescale 1ns / 1ps
// Packet checker for the camera frame capture framer: tracks the framing sequence
// from accepted pin samples and compares every packet word, in order, field by field.
// Depends on cfc_pkg and the cfc_pix_if / cfc_pkt_if channel interfaces.
module cfc_packet_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data,
	cfc_pix_if                             pix,
	cfc_pkt_if                             pkt,
	output int                             fail_count,
	output int                             words_waiting,
	output int                             words_checked,
	output logic                           framer_idle
);
	import cfc_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] tx_byte;
		logic              run_last;
		logic              packet_end;
	} pkt_word_t;

	// sync header, first word in the top byte
	localparam logic [HDR_LEN*BYTE_W-1:0] SYNC_HEADER = 80'h535A4859000C58020002;

	phase_t           phase;
	logic [COL_W-1:0] row_bytes;
	logic [DIM_W-1:0] rows_done;
	logic [DIM_W-1:0] width_px;
	logic [DIM_W-1:0] height_rows;
	pkt_word_t        expected_words[$];
	int               n_fail;
	int               n_checked;

	function automatic pkt_word_t pkt_word(input logic [BYTE_W-1:0] b, input logic last,
			input logic closes);
		pkt_word_t w;
		w.tx_byte    = b;
		w.run_last   = last;
		w.packet_end = closes;
		return w;
	endfunction

	function automatic bit field_matches(input string field, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, field, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// one pin sample: advances at most one wait and queues the words it produces
	task automatic predict_sample(input logic start, input logic vs, input logic hr,
			input logic pc, input logic [BYTE_W-1:0] data);
		case (phase)
			PH_IDLE: begin
				if (start) begin
					for (int i = 0; i < HDR_LEN; i++)
						expected_words.push_back(pkt_word(
							SYNC_HEADER[(HDR_LEN - 1 - i) * BYTE_W +: BYTE_W],
							i == HDR_LEN - 1, 1'b0));
					phase = PH_VS_HIGH;
				end
			end
			PH_VS_HIGH: begin
				if (vs)
					phase = PH_VS_LOW;
			end
			PH_VS_LOW: begin
				if (!vs) begin
					rows_done = '0;
					phase = (height_rows == '0) ? PH_VS_END : PH_HREF_HIGH;
				end
			end
			PH_HREF_HIGH: begin
				if (hr) begin
					row_bytes = '0;
					phase = (width_px == '0) ? PH_HREF_LOW : PH_PCLK_HIGH;
				end
			end
			PH_PCLK_HIGH: begin
				if (pc) begin
					expected_words.push_back(pkt_word(data, 1'b1, 1'b0));
					row_bytes = row_bytes + 1'b1;
					phase = PH_PCLK_LOW;
				end
			end
			PH_PCLK_LOW: begin
				// width may change mid-row, so compare rather than test equality
				if (!pc)
					phase = (row_bytes >= {width_px, 1'b0}) ? PH_HREF_LOW : PH_PCLK_HIGH;
			end
			PH_HREF_LOW: begin
				if (!hr) begin
					rows_done = rows_done + 1'b1;
					phase = (rows_done >= height_rows) ? PH_VS_END : PH_HREF_HIGH;
				end
			end
			PH_VS_END: begin
				if (vs) begin
					expected_words.push_back(pkt_word(TRAILER_BYTE, 1'b0, 1'b0));
					expected_words.push_back(pkt_word(TRAILER_BYTE, 1'b1, 1'b1));
					phase = PH_IDLE;
				end
			end
			default: begin
				phase = PH_IDLE;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pkt_word_t want;
		bit        ok;
		if (!arst_n) begin
			phase       = PH_IDLE;
			row_bytes   = '0;
			rows_done   = '0;
			width_px    = WIDTH_RST;
			height_rows = HEIGHT_RST;
			expected_words.delete();
			n_fail      = 0;
			n_checked   = 0;
			fail_count    <= 0;
			words_waiting <= 0;
			words_checked <= 0;
			framer_idle   <= 1'b1;
		end else begin
			if (pix.valid && pix.ready)
				predict_sample(pix.start_req, pix.vsync, pix.href, pix.pclk, pix.pixel_byte);
			// a register write at this edge applies from the next sample on
			if (cfg_we) begin
				case (cfg_idx)
					CFG_FRAME_WIDTH:  width_px = cfg_data;
					CFG_FRAME_HEIGHT: height_rows = cfg_data;
					default: ;
				endcase
			end
			if (pkt.valid && pkt.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected packet word, expected none, got %0h", $time,
						pkt.tx_byte);
					n_fail++;
				end else begin
					want = expected_words.pop_front();
					ok = field_matches("tx_byte", want.tx_byte, pkt.tx_byte);
					ok &= field_matches("run_last", BYTE_W'(want.run_last),
						BYTE_W'(pkt.run_last));
					ok &= field_matches("packet_end", BYTE_W'(want.packet_end),
						BYTE_W'(pkt.packet_end));
					if (!ok)
						n_fail++;
					n_checked++;
				end
			end
			fail_count    <= n_fail;
			words_waiting <= expected_words.size();
			words_checked <= n_checked;
			framer_idle   <= (phase == PH_IDLE);
		end
	end

endmodule

// File: dv/camera_frame_capture_framer_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for camera_frame_capture_framer_unit: clock, reset, register writes,
// pin-sample stimulus and packet back-pressure; the verdict comes from cfc_packet_checker.
// Depends on cfc_pkg, cfc_if and cfc_packet_checker.
module camera_frame_capture_framer_unit_tb;
	import cfc_pkg::*;

	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int RANDOM_ITEMS = 260;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 16;

	// bit positions in a {vsync, href, pclk} triple
	typedef enum int {
		PIN_PC = 0,
		PIN_HR = 1,
		PIN_VS = 2
	} pin_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cfc_pix_if pix_ch();
	cfc_pkt_if pkt_ch();

	int               fail_count;
	int               words_waiting;
	int               words_checked;
	logic             framer_idle;
	int               cycles = 0;
	int               samples_sent = 0;
	int               frames_done = 0;
	int               wellformed = 0;
	int               tx_quiet = 0;
	int               rx_quiet = 0;
	bit               long_hold = 1'b0;
	logic [DIM_W-1:0] cur_w = WIDTH_RST;
	logic [DIM_W-1:0] cur_h = HEIGHT_RST;

	camera_frame_capture_framer_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pix      (pix_ch),
		.pkt      (pkt_ch)
	);

	cfc_packet_checker pkt_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.pix           (pix_ch),
		.pkt           (pkt_ch),
		.fail_count    (fail_count),
		.words_waiting (words_waiting),
		.words_checked (words_checked),
		.framer_idle   (framer_idle)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[camera_frame_capture_framer_unit] ERROR");
			$finish;
		end
	end

	// idle cycles before the next word; now and then a stretch with none
	function automatic int draw_gap(ref int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0)
			quiet = $urandom_range(8, 40);
		return $urandom_range(0, 19);
	endfunction

	// called and returns at a falling edge; valid stays up for a back-to-back word
	task automatic send_sample(input logic start, input logic vs, input logic hr,
			input logic pc, input logic [BYTE_W-1:0] data);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap != 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid      <= 1'b1;
		pix_ch.start_req  <= start;
		pix_ch.vsync      <= vs;
		pix_ch.href       <= hr;
		pix_ch.pclk       <= pc;
		pix_ch.pixel_byte <= data;
		do @(posedge clk); while (!pix_ch.ready);
		@(negedge clk);
		samples_sent++;
	endtask

	// zero or more samples that do not satisfy the wait, then one that does
	task automatic wait_pin(input pin_t pin, input logic level, input int noise_pct);
		logic [2:0] pins;
		bit         stay;
		stay = 1'b1;
		while (stay) begin
			stay = ($urandom_range(0, 99) < noise_pct);
			pins = 3'($urandom);
			pins[int'(pin)] = stay ? !level : level;
			send_sample(1'($urandom), pins[PIN_VS], pins[PIN_HR], pins[PIN_PC], 8'($urandom));
		end
		wellformed++;
	endtask

	task automatic capture_frame(input int noise_pct);
		repeat ($urandom_range(0, 2))
			send_sample(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
		send_sample(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
		wellformed++;
		wait_pin(PIN_VS, 1'b1, noise_pct);
		wait_pin(PIN_VS, 1'b0, noise_pct);
		for (int r = 0; r < cur_h; r++) begin
			wait_pin(PIN_HR, 1'b1, noise_pct);
			for (int b = 0; b < 2 * cur_w; b++) begin
				wait_pin(PIN_PC, 1'b1, noise_pct);
				wait_pin(PIN_PC, 1'b0, noise_pct);
			end
			wait_pin(PIN_HR, 1'b0, noise_pct);
		end
		wait_pin(PIN_VS, 1'b1, noise_pct);
		frames_done++;
	endtask

	// random junk, then all pins toggling together until the framer is back at idle
	task automatic scramble_then_recover();
		logic flip;
		flip = 1'b1;
		repeat ($urandom_range(4, 16))
			send_sample(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
		while (!framer_idle) begin
			send_sample(1'b0, flip, flip, flip, 8'($urandom));
			flip = !flip;
		end
	endtask

	task automatic settle_block();
		pix_ch.valid <= 1'b0;
		@(negedge clk);
		while (words_waiting != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		settle_block();
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		cur_w = w;
		cur_h = h;
	endtask

	initial begin : packet_sink
		int gap;
		pkt_ch.ready <= 1'b0;
		@(negedge clk);
		forever begin
			if (long_hold) begin
				pkt_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold = 1'b0;
			end else begin
				gap = draw_gap(rx_quiet);
				if (gap != 0) begin
					pkt_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			pkt_ch.ready <= 1'b1;
			do @(posedge clk); while (!pkt_ch.valid);
			@(negedge clk);
		end
	end

	initial begin : pin_source
		int base;
		pix_ch.valid      <= 1'b0;
		pix_ch.start_req  <= 1'b0;
		pix_ch.vsync      <= 1'b0;
		pix_ch.href       <= 1'b0;
		pix_ch.pclk       <= 1'b0;
		pix_ch.pixel_byte <= '0;
		cfg_we            <= 1'b0;
		cfg_idx           <= '0;
		cfg_data          <= '0;
		arst_n            <= 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ignored while idle
		send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);

		// one pixel, one row; start while busy and start on the trailer are ignored
		set_dims(10'd1, 10'd1);
		send_sample(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
		send_sample(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'hA5);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0, 8'h3C);
		send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
		send_sample(1'b0, 1'b1, 1'b1, 1'b0, 8'hFF);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0, 8'h55);
		send_sample(1'b0, 1'b0, 1'b0, 1'b0, 8'hAA);
		send_sample(1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
		frames_done++;

		// zero width: rows carry no words
		set_dims(10'd0, 10'd2);
		send_sample(1'b1, 1'b0, 1'b0, 1'b0, 8'h12);
		send_sample(1'b0, 1'b1, 1'b0, 1'b0, 8'h34);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1, 8'h56);
		send_sample(1'b0, 1'b0, 1'b1, 1'b0, 8'h78);
		send_sample(1'b0, 1'b0, 1'b0, 1'b1, 8'h9A);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'hBC);
		send_sample(1'b0, 1'b1, 1'b0, 1'b0, 8'hDE);
		send_sample(1'b0, 1'b1, 1'b0, 1'b0, 8'hF0);
		frames_done++;

		// zero height: straight from vsync low to the trailer wait
		set_dims(10'd1, 10'd0);
		send_sample(1'b1, 1'b0, 1'b1, 1'b1, 8'h0F);
		send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'h87);
		send_sample(1'b0, 1'b0, 1'b1, 1'b1, 8'h69);
		send_sample(1'b0, 1'b1, 1'b1, 1'b1, 8'hC3);
		frames_done++;

		// random frames; the first runs against a long output stall
		base = wellformed;
		set_dims(10'd4, 10'd3);
		long_hold = 1'b1;
		capture_frame(0);
		while (wellformed - base < RANDOM_ITEMS) begin
			set_dims(DIM_W'($urandom_range(0, 4)), DIM_W'($urandom_range(0, 3)));
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 3) == 0)
					scramble_then_recover();
				capture_frame($urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 50));
			end
		end

		// largest width value, no rows
		set_dims(10'd1023, 10'd0);
		capture_frame(0);

		settle_block();
		$display("covered %0d pin samples in %0d frames, %0d packet words checked",
			samples_sent, frames_done, words_checked);
		$display("widths 0 to 4 and 1023, heights 0 to 3, random gaps and a %0d-cycle stall",
			LONG_HOLD);
		if (fail_count == 0 && words_waiting == 0)
			$display("[camera_frame_capture_framer_unit] OK");
		else
			$display("[camera_frame_capture_framer_unit] ERROR");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/cfc_pkg.sv
rtl/cfc_if.sv
rtl/cfc_ctrl.sv
rtl/cfc_emit.sv
rtl/camera_frame_capture_framer_unit.sv
rtl/cfc_checker.sv
dv/cfc_packet_checker.sv
dv/camera_frame_capture_framer_unit_tb.sv
